// File: design/gvr_pkg.sv
// Shared types and constants for the Givens rotation coefficient block.
`timescale 1ns / 1ps
package gvr_pkg;

   // Default width of the raw input operands.
   localparam int IN_WIDTH_DEF = 32;

   // Width of an operand magnitude after normalization.
   localparam int MAG_WIDTH = 31;

   // Quotient bits of the divider and root bits of the square root.
   localparam int DIV_STEPS  = 63;
   localparam int SQRT_STEPS = 32;

   // Latency of one coefficient lane: divider, square root, rounding.
   localparam int LANE_LATENCY = DIV_STEPS + SQRT_STEPS + 1;

   // The value 1.0 in signed Q2.30.
   localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

   // Input transaction payload.
   typedef struct packed {
      logic signed [31:0] pivot_value;
      logic signed [31:0] target_value;
   } req_type;

   // Result transaction payload.
   typedef struct packed {
      logic signed [31:0] cos_value;
      logic signed [31:0] sin_value;
   } rsp_type;

   // Control bits that travel alongside the data of one transaction.
   typedef struct packed {
      logic valid;
      logic flip;
      logic bzero;
      logic bgt;
   } flag_type;

endpackage

// File: design/givens_rotation_coefficients_top.sv
// Top level of the Givens rotation coefficient block.
`timescale 1ns / 1ps
// Computes the cosine and sine of the plane rotation that zeroes a target
// value against a pivot value. Inputs are signed Q16.16, results signed Q2.30,
// each magnitude rounded to nearest with ties away from zero.
//
// The req_ channel carries one pivot/target pair per transaction and the rsp_
// channel one cosine/sine pair. Both channels use valid and stall; a
// transaction moves on a rising edge with valid high and stall low.
//
// Throughput is one transaction per cycle while no held result stalls it.
// The path runs through the input register, normalization, squares, sum,
// a 63-stage restoring divider, a 32-stage square root, rounding and the
// output register.
//
// The whole pipeline advances together. When the receiver stalls a valid
// result, every stage holds and req_stall rises in the same cycle, so nothing
// is lost or repeated. Synchronous reset clears all valid bits; data registers
// are not reset.
module givens_rotation_coefficients_top #(
   parameter int IN_WIDTH = gvr_pkg::IN_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gvr_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gvr_pkg::rsp_type rsp_payload
);

   localparam int MW  = (IN_WIDTH > 32) ? IN_WIDTH : 32;
   localparam int NSH = (IN_WIDTH > 31) ? IN_WIDTH - 31 : 1;
   localparam int L   = gvr_pkg::LANE_LATENCY;
   localparam int M   = gvr_pkg::MAG_WIDTH;

   logic advance;

   logic [63:0]       pivot_ext;
   logic [63:0]       target_ext;
   logic [IN_WIDTH-1:0] pivot_raw;
   logic [IN_WIDTH-1:0] target_raw;
   logic [IN_WIDTH-1:0] pivot_mag;
   logic [IN_WIDTH-1:0] target_mag;

   // Input stage registers.
   logic [MW-1:0]     a_ff;
   logic [MW-1:0]     b_ff;
   gvr_pkg::flag_type in_flag_ff;

   // Normalization stage registers.
   logic [MW-1:0]     na_ff   [0:NSH-1];
   logic [MW-1:0]     nb_ff   [0:NSH-1];
   gvr_pkg::flag_type nflag_ff [0:NSH-1];

   // Square and sum stage registers.
   logic [2*M-1:0]    asq_ff;
   logic [2*M-1:0]    bsq_ff;
   gvr_pkg::flag_type sq_flag_ff;
   logic [2*M-1:0]    asq2_ff;
   logic [2*M-1:0]    bsq2_ff;
   logic [2*M:0]      sum_ff;
   gvr_pkg::flag_type sum_flag_ff;

   // Flags that follow the coefficient lanes.
   gvr_pkg::flag_type lflag_ff [0:L-1];

   logic [M-1:0] ca;
   logic [M-1:0] cb;
   logic [31:0]  ca_ext;
   logic [31:0]  cb_ext;

   logic             rsp_valid_ff;
   gvr_pkg::rsp_type rsp_ff;

   // The whole pipeline moves unless a finished result is held by the receiver.
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // Split the operands into sign and magnitude.
   assign pivot_ext  = {32'd0, req_payload.pivot_value};
   assign target_ext = {32'd0, req_payload.target_value};
   assign pivot_raw  = pivot_ext[IN_WIDTH-1:0];
   assign target_raw = target_ext[IN_WIDTH-1:0];
   assign pivot_mag  = pivot_raw[IN_WIDTH-1] ? (~pivot_raw + 1'b1) : pivot_raw;
   assign target_mag = target_raw[IN_WIDTH-1] ? (~target_raw + 1'b1) : target_raw;

   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff <= MW'(pivot_mag);
         b_ff <= MW'(target_mag);
         in_flag_ff.flip  <= (pivot_mag != '0) &&
                             (pivot_raw[IN_WIDTH-1] == target_raw[IN_WIDTH-1]);
         in_flag_ff.bzero <= target_mag == '0;
         in_flag_ff.bgt   <= 1'b0;
      end
      if (reset) begin
         in_flag_ff.valid <= 1'b0;
      end else if (advance) begin
         in_flag_ff.valid <= req_valid;
      end
   end

   // Halve both magnitudes, one bit a stage, while the larger needs more than 31 bits.
   genvar k;
   for (k = 0; k < NSH; k++) begin : g_norm
      logic [MW-1:0]     a_in;
      logic [MW-1:0]     b_in;
      gvr_pkg::flag_type f_in;
      logic [MW-1:0]     both;
      logic              wide;
      if (k == 0) begin : g_first
         assign a_in = a_ff;
         assign b_in = b_ff;
         assign f_in = in_flag_ff;
      end else begin : g_next
         assign a_in = na_ff[k-1];
         assign b_in = nb_ff[k-1];
         assign f_in = nflag_ff[k-1];
      end
      assign both = a_in | b_in;
      assign wide = |both[MW-1:M];
      always_ff @(posedge clock) begin
         if (advance) begin
            na_ff[k] <= wide ? (a_in >> 1) : a_in;
            nb_ff[k] <= wide ? (b_in >> 1) : b_in;
            nflag_ff[k].flip  <= f_in.flip;
            nflag_ff[k].bzero <= f_in.bzero;
            nflag_ff[k].bgt   <= f_in.bgt;
         end
         if (reset) begin
            nflag_ff[k].valid <= 1'b0;
         end else if (advance) begin
            nflag_ff[k].valid <= f_in.valid;
         end
      end
   end

   // Squares of the normalized magnitudes, then their sum.
   always_ff @(posedge clock) begin
      if (advance) begin
         asq_ff <= na_ff[NSH-1][M-1:0] * na_ff[NSH-1][M-1:0];
         bsq_ff <= nb_ff[NSH-1][M-1:0] * nb_ff[NSH-1][M-1:0];
         sq_flag_ff.flip  <= nflag_ff[NSH-1].flip;
         sq_flag_ff.bzero <= nflag_ff[NSH-1].bzero;
         sq_flag_ff.bgt   <= nb_ff[NSH-1][M-1:0] > na_ff[NSH-1][M-1:0];
         asq2_ff <= asq_ff;
         bsq2_ff <= bsq_ff;
         sum_ff  <= {1'b0, asq_ff} + {1'b0, bsq_ff};
         sum_flag_ff.flip  <= sq_flag_ff.flip;
         sum_flag_ff.bzero <= sq_flag_ff.bzero;
         sum_flag_ff.bgt   <= sq_flag_ff.bgt;
      end
      if (reset) begin
         sq_flag_ff.valid  <= 1'b0;
         sum_flag_ff.valid <= 1'b0;
      end else if (advance) begin
         sq_flag_ff.valid  <= nflag_ff[NSH-1].valid;
         sum_flag_ff.valid <= sq_flag_ff.valid;
      end
   end

   // Cosine and sine magnitude lanes.
   gvr_coef u_coef_a (
      .clock  (clock),
      .enable (advance),
      .xsq    (asq2_ff),
      .sum    (sum_ff),
      .coef   (ca)
   );

   gvr_coef u_coef_b (
      .clock  (clock),
      .enable (advance),
      .xsq    (bsq2_ff),
      .sum    (sum_ff),
      .coef   (cb)
   );

   // Flags follow the lanes stage by stage.
   for (k = 0; k < L; k++) begin : g_flag
      gvr_pkg::flag_type f_in;
      if (k == 0) begin : g_first
         assign f_in = sum_flag_ff;
      end else begin : g_next
         assign f_in = lflag_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            lflag_ff[k].flip  <= f_in.flip;
            lflag_ff[k].bzero <= f_in.bzero;
            lflag_ff[k].bgt   <= f_in.bgt;
         end
         if (reset) begin
            lflag_ff[k].valid <= 1'b0;
         end else if (advance) begin
            lflag_ff[k].valid <= f_in.valid;
         end
      end
   end

   // Apply signs and the zero-target case, then register the result.
   assign ca_ext = {1'b0, ca};
   assign cb_ext = {1'b0, cb};

   always_ff @(posedge clock) begin
      if (advance) begin
         if (lflag_ff[L-1].bzero) begin
            rsp_ff.cos_value <= gvr_pkg::ONE_Q30;
            rsp_ff.sin_value <= '0;
         end else begin
            rsp_ff.cos_value <= (lflag_ff[L-1].bgt && lflag_ff[L-1].flip) ?
                                (~ca_ext + 32'd1) : ca_ext;
            rsp_ff.sin_value <= (!lflag_ff[L-1].bgt && lflag_ff[L-1].flip) ?
                                (~cb_ext + 32'd1) : cb_ext;
         end
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= lflag_ff[L-1].valid;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // The input side is held exactly while a result waits on the receiver.
   a_stall_link : assert property (@(posedge clock)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow the held result");

   // Both coefficients stay within plus or minus one.
   a_cos_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_payload.cos_value) <= $signed(gvr_pkg::ONE_Q30) &&
                     $signed(rsp_payload.cos_value) >= -$signed(gvr_pkg::ONE_Q30)))
      else $error("cosine out of range");

   a_sin_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_payload.sin_value) <= $signed(gvr_pkg::ONE_Q30) &&
                     $signed(rsp_payload.sin_value) >= -$signed(gvr_pkg::ONE_Q30)))
      else $error("sine out of range");

   // A zero cosine only comes with a full positive sine.
   a_zero_cos : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.cos_value == '0) |->
         (rsp_payload.sin_value == gvr_pkg::ONE_Q30))
      else $error("zero cosine without unit sine");

endmodule

// File: design/gvr_coef.sv
// One coefficient lane: round(2^30 * x / sqrt(sum)) by a pipelined divider and square root.
`timescale 1ns / 1ps
module gvr_coef (
   input  logic                            clock,
   input  logic                            enable,
   input  logic [2*gvr_pkg::MAG_WIDTH-1:0] xsq,
   input  logic [2*gvr_pkg::MAG_WIDTH:0]   sum,
   output logic [gvr_pkg::MAG_WIDTH-1:0]   coef
);

   localparam int DS = gvr_pkg::DIV_STEPS;
   localparam int SS = gvr_pkg::SQRT_STEPS;

   // Divider registers: partial remainder, quotient so far, divisor.
   logic [63:0] rem_ff  [0:DS-1];
   logic [62:0] quo_ff  [0:DS-1];
   logic [62:0] dsum_ff [0:DS-1];

   // Square root registers: remaining radicand and root so far.
   logic [63:0] num_ff [0:SS-1];
   logic [63:0] res_ff [0:SS-1];

   logic [gvr_pkg::MAG_WIDTH-1:0] coef_ff;
   logic [64:0] round_in;

   genvar k;

   // Restoring division D = floor(2^62 * xsq / sum), one quotient bit a stage.
   for (k = 0; k < DS; k++) begin : g_div
      logic [63:0] r_in;
      logic [62:0] q_in;
      logic [62:0] s_in;
      logic [63:0] r_sub;
      logic        ge;
      if (k == 0) begin : g_first
         assign r_in = {2'b00, xsq};
         assign q_in = '0;
         assign s_in = sum;
      end else begin : g_next
         assign r_in = rem_ff[k-1];
         assign q_in = quo_ff[k-1];
         assign s_in = dsum_ff[k-1];
      end
      assign ge    = r_in >= {1'b0, s_in};
      assign r_sub = ge ? (r_in - {1'b0, s_in}) : r_in;
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= {r_sub[62:0], 1'b0};
            quo_ff[k]  <= {q_in[61:0], ge};
            dsum_ff[k] <= s_in;
         end
      end
   end

   // Digit-by-digit integer square root of D, one root bit a stage.
   for (k = 0; k < SS; k++) begin : g_sqrt
      localparam logic [63:0] BIT_W = 64'd1 << (62 - 2 * k);
      logic [63:0] n_in;
      logic [63:0] r_in;
      logic [63:0] trial;
      logic        ge;
      if (k == 0) begin : g_first
         assign n_in = {1'b0, quo_ff[DS-1]};
         assign r_in = '0;
      end else begin : g_next
         assign n_in = num_ff[k-1];
         assign r_in = res_ff[k-1];
      end
      assign trial = r_in + BIT_W;
      assign ge    = n_in >= trial;
      always_ff @(posedge clock) begin
         if (enable) begin
            num_ff[k] <= ge ? (n_in - trial) : n_in;
            res_ff[k] <= ge ? ((r_in >> 1) + BIT_W) : (r_in >> 1);
         end
      end
   end

   // The largest odd d with d^2 <= D is tied to the root s: q = (s + 1) / 2.
   assign round_in = {1'b0, res_ff[SS-1]} + 65'd1;

   always_ff @(posedge clock) begin
      if (enable) begin
         coef_ff <= round_in[gvr_pkg::MAG_WIDTH:1];
      end
   end

   assign coef = coef_ff;

endmodule
